FILE: rtl/rolling_hash_string_matcher_macros.svh
// ----------------------------------------------------------------------------
// rolling_hash_string_matcher_macros
// Assertion helpers used by the rolling hash matcher module.
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_STRING_MATCHER_MACROS_SVH
`define ROLLING_HASH_STRING_MATCHER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RHSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rolling hash matcher: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define RHSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rolling hash matcher: next-cycle check failed");

`endif

FILE: rtl/rhsm_pkg.sv
// ----------------------------------------------------------------------------
// rhsm_pkg
// Shared constants, register indexes and helpers of the rolling hash matcher.
// ----------------------------------------------------------------------------
package rhsm_pkg;

    // default sizing
    localparam int RHSM_MAX_PATTERN  = 16;
    localparam int RHSM_MODULUS_BITS = 16;

    // register widths
    localparam int RADIX_W   = 9;
    localparam int MOD_W     = 16;
    localparam int LEN_W     = 5;
    localparam int PAT_W     = 64;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef logic [7:0] t_byte;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd4;

    // pattern byte j, zero beyond the sixteen stored bytes
    function automatic t_byte pattern_byte(input logic [PAT_W-1:0] lo,
                                           input logic [PAT_W-1:0] hi,
                                           input logic [7:0] j);
        logic [2*PAT_W-1:0] pat;
        pat = {hi, lo};
        if (j < 8'd16) begin
            return pat[{j[3:0], 3'b000} +: 8];
        end
        return 8'h00;
    endfunction

endpackage

FILE: rtl/rolling_hash_string_matcher.sv
// ----------------------------------------------------------------------------
// rolling_hash_string_matcher
// Streams text bytes and keeps a window of the last m bytes with a rolling
// hash modulo q in radix d; a hash hit is checked byte by byte against the
// pattern and reported as a match or a false hit. All modular arithmetic
// runs through one bit-serial multiply-add unit, so the cost of a byte is
// set by that unit. A byte with a full window first takes out the share of
// the byte that leaves; an operand that is not already below q (after a
// modulus change) adds a reduction pass, and a hash hit adds a byte-by-byte
// check of the window. A text start (first set, or the first byte after
// reset) first computes d^(m-1) mod q and the pattern hash. One result is
// produced per byte; the next byte is taken while a result still waits in
// the output register.
// ----------------------------------------------------------------------------
`include "rolling_hash_string_matcher_macros.svh"

module rolling_hash_string_matcher
    import rhsm_pkg::*;
#(
    parameter int MAX_PATTERN  = RHSM_MAX_PATTERN,
    parameter int MODULUS_BITS = RHSM_MODULUS_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // text input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_first,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_match,
    output logic                 o_false_hit,
    output logic [31:0]          o_position,
    output logic [31:0]          o_false_count,
    output logic                 o_window_full
);

    localparam int QW = MODULUS_BITS;
    localparam int AW = (QW > RADIX_W) ? QW : RADIX_W;
    localparam int NW = $clog2(AW + 1);
    localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int FW = $clog2(MAX_PATTERN + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_PATTERN);
    localparam logic [PW-1:0] WP_LAST  = PW'(MAX_PATTERN - 1);

    // sequencer states
    localparam logic [4:0] S_IN   = 5'd0;
    localparam logic [4:0] S_HPW  = 5'd1;
    localparam logic [4:0] S_HPM  = 5'd2;
    localparam logic [4:0] S_PH   = 5'd3;
    localparam logic [4:0] S_PHM  = 5'd4;
    localparam logic [4:0] S_ITEM = 5'd5;
    localparam logic [4:0] S_HPR  = 5'd6;
    localparam logic [4:0] S_HPRW = 5'd7;
    localparam logic [4:0] S_SUB  = 5'd8;
    localparam logic [4:0] S_SUBW = 5'd9;
    localparam logic [4:0] S_TR   = 5'd10;
    localparam logic [4:0] S_TRW  = 5'd11;
    localparam logic [4:0] S_UPD  = 5'd12;
    localparam logic [4:0] S_UPDW = 5'd13;
    localparam logic [4:0] S_CHK  = 5'd14;
    localparam logic [4:0] S_CRD  = 5'd15;
    localparam logic [4:0] S_CCMP = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    // configuration registers
    logic [RADIX_W-1:0] r_radix;
    logic [MOD_W-1:0]   r_modulus;
    logic [LEN_W-1:0]   r_pattern_length;
    logic [PAT_W-1:0]   r_pattern_low;
    logic [PAT_W-1:0]   r_pattern_high;

    // control state
    logic [4:0] r_state, n_state;
    logic       r_started, n_started;
    logic       r_o_valid, n_o_valid;

    // datapath state
    logic [7:0]    r_byte, n_byte;
    logic [7:0]    r_old, n_old;
    logic [QW-1:0] r_text_hash, n_text_hash;
    logic [QW-1:0] r_pattern_hash, n_pattern_hash;
    logic [QW-1:0] r_hp, n_hp;
    logic [QW-1:0] r_hpq, n_hpq;
    logic [QW-1:0] r_sub, n_sub;
    logic [QW-1:0] r_t, n_t;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_j, n_j;
    logic [PW-1:0] r_wp, n_wp;
    logic [31:0]   r_start, n_start;
    logic [31:0]   r_false_total, n_false_total;
    logic          r_was_full, n_was_full;
    logic          r_full, n_full;
    logic          r_hit, n_hit;
    logic          r_same, n_same;

    // output registers
    logic        r_o_match, n_o_match;
    logic        r_o_false_hit, n_o_false_hit;
    logic [31:0] r_o_position, n_o_position;
    logic [31:0] r_o_false_count, n_o_false_count;
    logic        r_o_window_full, n_o_window_full;

    // window memory
    logic [7:0]    r_mem [MAX_PATTERN];
    logic [7:0]    r_rdata;
    logic          mem_we;
    logic          mem_re;
    logic [PW-1:0] mem_raddr;
    logic [PW-1:0] wp_inc;

    // serial arithmetic unit
    logic          mm_start;
    logic [AW-1:0] mm_a;
    logic [AW-1:0] mm_c;
    logic [QW-1:0] mm_b;
    logic [NW-1:0] mm_n;
    logic          mm_done;
    logic [QW-1:0] mm_result;

    // effective settings
    logic [QW-1:0] q_raw;
    logic [QW-1:0] eff_q;
    logic [7:0]    len_ext;
    logic [7:0]    m8;
    logic [FW-1:0] eff_m;
    logic [FW-1:0] m_less;

    // aligned serial operands
    logic [AW-1:0] d_al;
    logic [AW-1:0] byte_al;
    logic [AW-1:0] pb_al;
    logic [AW-1:0] old_al;
    logic [AW-1:0] hp_red_al;
    logic [AW-1:0] th_red_al;
    t_byte         pb_j;
    logic [QW-1:0] t_rolled;

    // address of the byte that arrived k steps before the newest one
    function automatic logic [PW-1:0] back_addr(input logic [PW-1:0] wp,
                                                input logic [PW-1:0] k);
        logic [PW:0] s;
        if (wp >= k) begin
            s = {1'b0, wp} - {1'b0, k};
        end else begin
            s = {1'b0, wp} + (PW+1)'(MAX_PATTERN) - {1'b0, k};
        end
        return s[PW-1:0];
    endfunction

    // clamp modulus and pattern length
    always_comb begin
        q_raw   = QW'(r_modulus);
        eff_q   = (q_raw < QW'(2)) ? QW'(2) : q_raw;
        len_ext = 8'(r_pattern_length);
        if (len_ext == 8'd0) begin
            m8 = 8'd1;
        end else if (len_ext > 8'(MAX_PATTERN)) begin
            m8 = 8'(MAX_PATTERN);
        end else begin
            m8 = len_ext;
        end
        eff_m  = FW'(m8);
        m_less = eff_m - FW'(1);
    end

    // operands left-aligned for msb-first processing
    always_comb begin
        pb_j      = pattern_byte(r_pattern_low, r_pattern_high, 8'(r_j));
        d_al      = AW'(r_radix) << (AW - RADIX_W);
        byte_al   = AW'(r_byte) << (AW - RADIX_W);
        pb_al     = AW'(pb_j) << (AW - RADIX_W);
        old_al    = AW'(r_old) << (AW - 8);
        hp_red_al = AW'(r_hp) << (AW - QW);
        th_red_al = AW'(r_text_hash) << (AW - QW);
        t_rolled  = r_t - r_sub + ((r_t < r_sub) ? eff_q : QW'(0));
        wp_inc    = (r_wp == WP_LAST) ? PW'(0) : r_wp + PW'(1);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix          <= RADIX_W'(2);
            r_modulus        <= MOD_W'(13);
            r_pattern_length <= LEN_W'(1);
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RADIX:        r_radix          <= i_cfg_data[RADIX_W-1:0];
                REG_MODULUS:      r_modulus        <= i_cfg_data[MOD_W-1:0];
                REG_PATTERN_LEN:  r_pattern_length <= i_cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:  r_pattern_low    <= i_cfg_data[PAT_W-1:0];
                REG_PATTERN_HIGH: r_pattern_high   <= i_cfg_data[PAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state         = r_state;
        n_started       = r_started;
        n_o_valid       = r_o_valid;
        n_byte          = r_byte;
        n_old           = r_old;
        n_text_hash     = r_text_hash;
        n_pattern_hash  = r_pattern_hash;
        n_hp            = r_hp;
        n_hpq           = r_hpq;
        n_sub           = r_sub;
        n_t             = r_t;
        n_fill          = r_fill;
        n_j             = r_j;
        n_wp            = r_wp;
        n_start         = r_start;
        n_false_total   = r_false_total;
        n_was_full      = r_was_full;
        n_full          = r_full;
        n_hit           = r_hit;
        n_same          = r_same;
        n_o_match       = r_o_match;
        n_o_false_hit   = r_o_false_hit;
        n_o_position    = r_o_position;
        n_o_false_count = r_o_false_count;
        n_o_window_full = r_o_window_full;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = r_wp;
        mm_start  = 1'b0;
        mm_a      = '0;
        mm_c      = '0;
        mm_b      = '0;
        mm_n      = NW'(RADIX_W);

        // output register drains independently of the sequencer
        if (i_out_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IN: begin
                if (i_in_valid) begin
                    n_byte = i_text_byte;
                    if (i_first || !r_started) begin
                        n_started     = 1'b1;
                        n_text_hash   = '0;
                        n_fill        = '0;
                        n_start       = '0;
                        n_false_total = '0;
                        n_hp          = QW'(1);
                        n_j           = '0;
                        n_state       = S_HPW;
                    end else begin
                        n_state = S_ITEM;
                    end
                end
            end
            // d^(m-1) mod q
            S_HPW: begin
                if ((r_j + FW'(1)) < eff_m) begin
                    mm_start = 1'b1;
                    mm_a     = d_al;
                    mm_b     = r_hp;
                    n_state  = S_HPM;
                end else begin
                    n_j            = '0;
                    n_pattern_hash = '0;
                    n_state        = S_PH;
                end
            end
            S_HPM: begin
                if (mm_done) begin
                    n_hp    = mm_result;
                    n_j     = r_j + FW'(1);
                    n_state = S_HPW;
                end
            end
            // pattern hash by horner over the pattern bytes
            S_PH: begin
                if (r_j < eff_m) begin
                    mm_start = 1'b1;
                    mm_a     = d_al;
                    mm_b     = r_pattern_hash;
                    mm_c     = pb_al;
                    n_state  = S_PHM;
                end else begin
                    n_state = S_ITEM;
                end
            end
            S_PHM: begin
                if (mm_done) begin
                    n_pattern_hash = mm_result;
                    n_j            = r_j + FW'(1);
                    n_state        = S_PH;
                end
            end
            // fetch the byte that leaves the window
            S_ITEM: begin
                n_was_full = (r_fill >= eff_m);
                if (r_fill >= eff_m) begin
                    mem_re    = 1'b1;
                    mem_raddr = back_addr(r_wp, PW'(m_less));
                    n_state   = S_HPR;
                end else begin
                    n_state = S_TR;
                end
            end
            S_HPR: begin
                n_old = r_rdata;
                if (r_hp < eff_q) begin
                    n_hpq   = r_hp;
                    n_state = S_SUB;
                end else begin
                    mm_start = 1'b1;
                    mm_c     = hp_red_al;
                    mm_n     = NW'(QW);
                    n_state  = S_HPRW;
                end
            end
            S_HPRW: begin
                if (mm_done) begin
                    n_hpq   = mm_result;
                    n_state = S_SUB;
                end
            end
            // contribution of the outgoing byte
            S_SUB: begin
                mm_start = 1'b1;
                mm_a     = old_al;
                mm_b     = r_hpq;
                mm_n     = NW'(8);
                n_state  = S_SUBW;
            end
            S_SUBW: begin
                if (mm_done) begin
                    n_sub   = mm_result;
                    n_state = S_TR;
                end
            end
            // bring the running hash below the current modulus
            S_TR: begin
                if (r_text_hash < eff_q) begin
                    n_t     = r_text_hash;
                    n_state = S_UPD;
                end else begin
                    mm_start = 1'b1;
                    mm_c     = th_red_al;
                    mm_n     = NW'(QW);
                    n_state  = S_TRW;
                end
            end
            S_TRW: begin
                if (mm_done) begin
                    n_t     = mm_result;
                    n_state = S_UPD;
                end
            end
            // rolling update: d * t + c
            S_UPD: begin
                mm_start = 1'b1;
                mm_a     = d_al;
                mm_b     = r_was_full ? t_rolled : r_t;
                mm_c     = byte_al;
                n_state  = S_UPDW;
            end
            S_UPDW: begin
                if (mm_done) begin
                    n_text_hash = mm_result;
                    mem_we      = 1'b1;
                    n_wp        = wp_inc;
                    if (r_was_full) begin
                        if (r_start != 32'hFFFF_FFFF) begin
                            n_start = r_start + 32'd1;
                        end
                    end else if (r_fill < FILL_MAX) begin
                        n_fill = r_fill + FW'(1);
                    end
                    n_state = S_CHK;
                end
            end
            // hash compare
            S_CHK: begin
                n_full = (r_fill >= eff_m);
                if ((r_fill >= eff_m) && (r_text_hash == r_pattern_hash)) begin
                    n_hit   = 1'b1;
                    n_same  = 1'b1;
                    n_j     = '0;
                    n_state = S_CRD;
                end else begin
                    n_hit   = 1'b0;
                    n_state = S_OUT;
                end
            end
            // byte-by-byte check of the window against the pattern
            S_CRD: begin
                mem_re    = 1'b1;
                mem_raddr = back_addr(r_wp, PW'(m_less - r_j));
                n_state   = S_CCMP;
            end
            S_CCMP: begin
                if (r_rdata != pb_j) begin
                    n_same = 1'b0;
                end
                if (r_j == m_less) begin
                    n_state = S_OUT;
                end else begin
                    n_j     = r_j + FW'(1);
                    n_state = S_CRD;
                end
            end
            // load the result once the output register is free
            S_OUT: begin
                if (!r_o_valid || i_out_ready) begin
                    if (r_hit && !r_same && (r_false_total != 32'hFFFF_FFFF)) begin
                        n_false_total = r_false_total + 32'd1;
                    end
                    n_o_match       = r_hit && r_same;
                    n_o_false_hit   = r_hit && !r_same;
                    n_o_position    = r_full ? r_start : 32'd0;
                    n_o_false_count = (r_hit && !r_same && (r_false_total != 32'hFFFF_FFFF))
                                    ? r_false_total + 32'd1 : r_false_total;
                    n_o_window_full = r_full;
                    n_o_valid       = 1'b1;
                    n_state         = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IN;
            r_started <= 1'b0;
            r_o_valid <= 1'b0;
            r_wp      <= '0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_o_valid <= n_o_valid;
            r_wp      <= n_wp;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_byte          <= n_byte;
        r_old           <= n_old;
        r_text_hash     <= n_text_hash;
        r_pattern_hash  <= n_pattern_hash;
        r_hp            <= n_hp;
        r_hpq           <= n_hpq;
        r_sub           <= n_sub;
        r_t             <= n_t;
        r_fill          <= n_fill;
        r_j             <= n_j;
        r_start         <= n_start;
        r_false_total   <= n_false_total;
        r_was_full      <= n_was_full;
        r_full          <= n_full;
        r_hit           <= n_hit;
        r_same          <= n_same;
        r_o_match       <= n_o_match;
        r_o_false_hit   <= n_o_false_hit;
        r_o_position    <= n_o_position;
        r_o_false_count <= n_o_false_count;
        r_o_window_full <= n_o_window_full;
    end

    // window memory, circular, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wp_inc] <= r_byte;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    rhsm_mulmod #(
        .QW (QW),
        .AW (AW)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (mm_a),
        .i_c      (mm_c),
        .i_b      (mm_b),
        .i_q      (eff_q),
        .i_nbits  (mm_n),
        .o_done   (mm_done),
        .o_result (mm_result)
    );

    assign o_in_ready    = (r_state == S_IN);
    assign o_out_valid   = r_o_valid;
    assign o_match       = r_o_match;
    assign o_false_hit   = r_o_false_hit;
    assign o_position    = r_o_position;
    assign o_false_count = r_o_false_count;
    assign o_window_full = r_o_window_full;

    // checks
    `RHSM_ASSERT_IMPL(a_mm_reduced, i_clk, i_rst_n, mm_done, mm_result < eff_q)
    `RHSM_ASSERT_IMPL(a_hash_reduced, i_clk, i_rst_n, r_state == S_CHK, r_text_hash < eff_q)
    `RHSM_ASSERT_IMPL(a_hit_full, i_clk, i_rst_n, o_out_valid && (o_match || o_false_hit), o_window_full)
    `RHSM_ASSERT_NEXT(a_out_drain, i_clk, i_rst_n, o_out_valid && i_out_ready && (r_state != S_OUT), !o_out_valid)

endmodule

FILE: rtl/rhsm_mulmod.sv
// ----------------------------------------------------------------------------
// rhsm_mulmod
// Bit-serial modular multiply-add: result = (a * b + c) mod q, one bit of a
// and c per cycle, most significant first, with b below q.
// ----------------------------------------------------------------------------
module rhsm_mulmod #(
    parameter int QW = 16,
    parameter int AW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [AW-1:0]        i_a,
    input  logic [AW-1:0]        i_c,
    input  logic [QW-1:0]        i_b,
    input  logic [QW-1:0]        i_q,
    input  logic [$clog2(AW+1)-1:0] i_nbits,
    output logic                 o_done,
    output logic [QW-1:0]        o_result
);

    localparam int CW = $clog2(AW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_a;
    logic [AW-1:0] r_c;
    logic [QW-1:0] r_b;
    logic [QW-1:0] r_acc;

    logic [QW+1:0] s0;
    logic [QW+1:0] s1;
    logic [QW+1:0] s2;
    logic [QW+1:0] qx;

    // one horner step: double, add, then up to two restoring subtracts
    always_comb begin
        qx = {2'b00, i_q};
        s0 = {1'b0, r_acc, 1'b0}
           + (r_a[AW-1] ? {2'b00, r_b} : {(QW+2){1'b0}})
           + (QW+2)'(r_c[AW-1]);
        s1 = (s0 >= qx) ? s0 - qx : s0;
        s2 = (s1 >= qx) ? s1 - qx : s1;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand shift registers and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_c   <= i_c;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= {r_a[AW-2:0], 1'b0};
            r_c   <= {r_c[AW-2:0], 1'b0};
            r_acc <= s2[QW-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

FILE: test/rolling_hash_string_matcher_test.sv
// ----------------------------------------------------------------------------
// rolling_hash_string_matcher_test
// Self-checking bench for the rolling hash matcher. A short directed table
// covers reset settings, out-of-range registers, window fill and mid-text
// register changes. Random text phases built around the programmed pattern
// follow, with random idling on both handshakes and one long output stall.
// Every result is checked field by field against the bench model or a typed row.
// ----------------------------------------------------------------------------
module rolling_hash_string_matcher_test;
    import rhsm_pkg::*;

    localparam int RANDOM_ITEMS    = 1250;
    localparam int IDLE_PCT        = 6;
    localparam int HOLD_OFF_PHASE  = 3;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_FIRST     = 6;
    localparam int QUIET_LAST      = 11;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 500;
    localparam int TIMEOUT_TICKS   = 30_000_000;
    localparam int MAX_REPORTS     = 50;
    localparam int PATTERN_BYTES   = 2 * PAT_W / 8;

    typedef longint unsigned t_wide;

    typedef struct packed {
        logic        match;
        logic        false_hit;
        logic [31:0] position;
        logic [31:0] false_total;
        logic        window_full;
    } t_match_result;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [MOD_W-1:0]   modulus;
        logic [LEN_W-1:0]   pat_len;
        logic [PAT_W-1:0]   pat_lo;
        logic [PAT_W-1:0]   pat_hi;
    } t_matcher_setting;

    typedef enum logic {ROW_SETTING, ROW_TEXT} t_row_kind;

    typedef struct packed {
        t_row_kind     kind;
        int            setting;
        t_byte         ch;
        logic          start;
        int            repeats;
        logic          typed;
        t_match_result want;
    } t_directed_row;

    // dut signals
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_byte                i_text_byte = '0;
    logic                 i_first = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_match;
    logic                 o_false_hit;
    logic [31:0]          o_position;
    logic [31:0]          o_false_count;
    logic                 o_window_full;

    // bench bookkeeping
    t_match_result pending_results [$];
    int unsigned   error_count = 0;
    int unsigned   results_checked = 0;
    int unsigned   in_idle_pct = IDLE_PCT;
    int unsigned   out_idle_pct = IDLE_PCT;
    bit            hold_off_request = 1'b0;
    logic          hold_off = 1'b0;

    // shadow registers, reset values
    logic [RADIX_W-1:0] cfg_radix = 9'd2;
    logic [MOD_W-1:0]   cfg_modulus = 16'd13;
    logic [LEN_W-1:0]   cfg_pat_len = 5'd1;
    logic [PAT_W-1:0]   cfg_pat_lo = '0;
    logic [PAT_W-1:0]   cfg_pat_hi = '0;

    // shadow matcher state, index 0 holds the newest byte
    t_byte       shadow_window [RHSM_MAX_PATTERN] = '{default: 8'h00};
    t_wide       shadow_text_hash = 0;
    t_wide       shadow_pattern_hash = 0;
    t_wide       shadow_high_power = 1;
    int unsigned shadow_fill = 0;
    logic [31:0] shadow_start = '0;
    logic [31:0] shadow_false = '0;
    bit          shadow_idle = 1'b1;

    // directed register settings
    t_matcher_setting directed_settings [4] = '{
        '{9'd0,   16'd0,    5'd0,  64'h0,                   64'h0},
        '{9'd511, 16'hFFFF, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
        '{9'd511, 16'hFFFF, 5'd2,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
        '{9'd256, 16'd1,    5'd16, 64'h0123_4567_89AB_CDEF, 64'h8000_0000_0000_0001}
    };

    // directed stimulus
    t_directed_row directed_table [13] = '{
        // leaving idle on reset settings: zero byte equals the zero pattern
        '{ROW_TEXT,    0, 8'h00, 1'b0, 1,  1'b1, '{1'b1, 1'b0, 32'd0, 32'd0, 1'b1}},
        // 13 hashes to zero modulo 13 but differs from the pattern
        '{ROW_TEXT,    0, 8'h0D, 1'b0, 1,  1'b1, '{1'b0, 1'b1, 32'd1, 32'd1, 1'b1}},
        // new text clears position and false count
        '{ROW_TEXT,    0, 8'hFF, 1'b1, 1,  1'b1, '{1'b0, 1'b0, 32'd0, 32'd0, 1'b1}},
        // radix zero, modulus and length below range
        '{ROW_SETTING, 0, 8'h00, 1'b0, 0,  1'b0, '0},
        '{ROW_TEXT,    0, 8'h01, 1'b1, 1,  1'b0, '0},
        '{ROW_TEXT,    0, 8'h02, 1'b0, 1,  1'b0, '0},
        // widest radix and modulus, length above range, all-ones pattern
        '{ROW_SETTING, 1, 8'h00, 1'b0, 0,  1'b0, '0},
        '{ROW_TEXT,    0, 8'hFF, 1'b1, 16, 1'b0, '0},
        // length shrinks in the middle of a text
        '{ROW_SETTING, 2, 8'h00, 1'b0, 0,  1'b0, '0},
        '{ROW_TEXT,    0, 8'hFF, 1'b0, 2,  1'b0, '0},
        // radix 256 with modulus one while the text runs on, then a new text
        '{ROW_SETTING, 3, 8'h00, 1'b0, 0,  1'b0, '0},
        '{ROW_TEXT,    0, 8'h80, 1'b0, 1,  1'b0, '0},
        '{ROW_TEXT,    0, 8'h00, 1'b1, 1,  1'b0, '0}
    };

    rolling_hash_string_matcher u_top (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // modulus and length as the block uses them
    function automatic t_wide modulus_in_use();
        return (cfg_modulus < 16'd2) ? 64'd2 : t_wide'(cfg_modulus);
    endfunction

    function automatic int unsigned length_in_use();
        int unsigned m;
        m = 32'(cfg_pat_len);
        if (m < 1) m = 1;
        if (m > RHSM_MAX_PATTERN) m = RHSM_MAX_PATTERN;
        return m;
    endfunction

    function automatic t_byte pattern_char(input int unsigned j);
        logic [2*PAT_W-1:0] pat;
        pat = {cfg_pat_hi, cfg_pat_lo};
        if (j >= PATTERN_BYTES) return 8'h00;
        return pat[8*j +: 8];
    endfunction

    // text start: clear the window, derive pattern hash and d^(m-1) mod q
    function automatic void begin_text();
        t_wide       q;
        t_wide       d;
        t_wide       h;
        t_wide       acc;
        int unsigned m;
        int unsigned j;
        q = modulus_in_use();
        m = length_in_use();
        d = t_wide'(cfg_radix);
        h = 64'd1 % q;
        acc = 0;
        foreach (shadow_window[k]) shadow_window[k] = 8'h00;
        shadow_text_hash = 0;
        shadow_fill = 0;
        shadow_start = '0;
        shadow_false = '0;
        for (j = 0; j + 1 < m; j++) h = (h * d) % q;
        for (j = 0; j < m; j++) acc = (d * acc + t_wide'(pattern_char(j))) % q;
        shadow_high_power = h;
        shadow_pattern_hash = acc;
        shadow_idle = 1'b0;
    endfunction

    // rolling hash update and match decision for one text byte
    function automatic t_match_result predict_match_result(input t_byte ch, input logic start);
        t_match_result r;
        t_wide         q;
        t_wide         d;
        t_wide         t;
        t_wide         sub;
        int unsigned   m;
        int unsigned   j;
        int unsigned   k;
        bit            full;
        bit            same;
        r = '0;
        if (start || shadow_idle) begin_text();
        q = modulus_in_use();
        m = length_in_use();
        d = t_wide'(cfg_radix);
        t = shadow_text_hash % q;
        if (shadow_fill >= m) begin
            // drop the oldest byte, then shift in the new one
            sub = (t_wide'(shadow_window[m-1]) * (shadow_high_power % q)) % q;
            t = (t + q - sub) % q;
            t = (d * t + t_wide'(ch)) % q;
            if (shadow_start != 32'hFFFF_FFFF) shadow_start = shadow_start + 32'd1;
        end else begin
            t = (d * t + t_wide'(ch)) % q;
            if (shadow_fill < RHSM_MAX_PATTERN) shadow_fill++;
        end
        shadow_text_hash = t;
        for (k = RHSM_MAX_PATTERN - 1; k > 0; k--) shadow_window[k] = shadow_window[k-1];
        shadow_window[0] = ch;
        full = (shadow_fill >= m);
        // hash hit: confirm byte by byte
        if (full && shadow_text_hash == shadow_pattern_hash) begin
            same = 1'b1;
            for (j = 0; j < m; j++) begin
                if (shadow_window[m-1-j] != pattern_char(j)) same = 1'b0;
            end
            if (same) begin
                r.match = 1'b1;
            end else begin
                r.false_hit = 1'b1;
                if (shadow_false != 32'hFFFF_FFFF) shadow_false = shadow_false + 32'd1;
            end
        end
        r.position = full ? shadow_start : 32'd0;
        r.false_total = shadow_false;
        r.window_full = full;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // one register write, shadow copy follows at the write edge
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (index)
            REG_RADIX:        cfg_radix = value[RADIX_W-1:0];
            REG_MODULUS:      cfg_modulus = value[MOD_W-1:0];
            REG_PATTERN_LEN:  cfg_pat_len = value[LEN_W-1:0];
            REG_PATTERN_LOW:  cfg_pat_lo = value[PAT_W-1:0];
            REG_PATTERN_HIGH: cfg_pat_hi = value[PAT_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // reprogram all registers once the block has drained
    task automatic apply_setting(input t_matcher_setting s);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        write_register(REG_RADIX, {{(CFG_W-RADIX_W){1'b0}}, s.radix});
        write_register(REG_MODULUS, {{(CFG_W-MOD_W){1'b0}}, s.modulus});
        write_register(REG_PATTERN_LEN, {{(CFG_W-LEN_W){1'b0}}, s.pat_len});
        write_register(REG_PATTERN_LOW, s.pat_lo);
        write_register(REG_PATTERN_HIGH, s.pat_hi);
    endtask

    // offer one text byte; valid stays up for the caller to reuse or lower
    task automatic offer_text_byte(input t_byte ch, input logic start,
                                   input logic typed, input t_match_result want);
        t_match_result predicted;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_text_byte <= ch;
        i_first <= start;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        predicted = predict_match_result(ch, start);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    // output ready with random idling and the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // long receiver stall so the block backs up into its input
    initial begin : receiver_hold_off
        wait (hold_off_request);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_match_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (o_match !== want.match)
                    report_mismatch($sformatf("result %0d match %0b, expected %0b",
                                              results_checked, o_match, want.match));
                if (o_false_hit !== want.false_hit)
                    report_mismatch($sformatf("result %0d false_hit %0b, expected %0b",
                                              results_checked, o_false_hit, want.false_hit));
                if (o_position !== want.position)
                    report_mismatch($sformatf("result %0d position %0d, expected %0d",
                                              results_checked, o_position, want.position));
                if (o_false_count !== want.false_total)
                    report_mismatch($sformatf("result %0d false total %0d, expected %0d",
                                              results_checked, o_false_count,
                                              want.false_total));
                if (o_window_full !== want.window_full)
                    report_mismatch($sformatf("result %0d window_full %0b, expected %0b",
                                              results_checked, o_window_full,
                                              want.window_full));
            end
            results_checked++;
        end
    end

    // stimulus
    initial begin : stimulus
        t_matcher_setting s;
        t_byte            phase_text [$];
        logic [127:0]     pat_all;
        int unsigned      random_items;
        int unsigned      phase;
        int unsigned      n;
        int unsigned      m;
        int unsigned      j;
        int unsigned      k;
        int unsigned      r;
        int unsigned      sel;
        int unsigned      cut;
        int unsigned      alpha;
        int unsigned      base;
        int unsigned      wait_cycles;
        int               rep;
        bit               new_text;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_table[row]) begin
            if (directed_table[row].kind == ROW_SETTING) begin
                apply_setting(directed_settings[directed_table[row].setting]);
            end else begin
                for (rep = 0; rep < directed_table[row].repeats; rep++) begin
                    offer_text_byte(directed_table[row].ch,
                                    directed_table[row].start && rep == 0,
                                    directed_table[row].typed, directed_table[row].want);
                end
            end
        end

        // random phases, each with fresh settings and pattern-heavy text
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            sel = $urandom_range(9);
            case (sel)
                0: s.radix = 9'd0;
                1: s.radix = 9'd1;
                2: s.radix = 9'd511;
                3: s.radix = 9'd256;
                4: s.radix = 9'd2;
                default: s.radix = RADIX_W'($urandom_range(256, 2));
            endcase
            sel = $urandom_range(9);
            case (sel)
                0: s.modulus = 16'd0;
                1: s.modulus = 16'd1;
                2: s.modulus = 16'hFFFF;
                3: s.modulus = 16'd2;
                4, 5, 6: s.modulus = MOD_W'($urandom_range(40, 3));
                default: s.modulus = MOD_W'($urandom_range(65535, 2));
            endcase
            sel = $urandom_range(9);
            case (sel)
                0: s.pat_len = 5'd0;
                1: s.pat_len = LEN_W'($urandom_range(31, 17));
                2: s.pat_len = 5'd16;
                default: s.pat_len = LEN_W'($urandom_range(12, 1));
            endcase
            // pattern mostly from a small alphabet so the text can repeat it
            sel = $urandom_range(9);
            alpha = (sel < 4) ? 2 : (sel < 7) ? 4 : 256;
            base = $urandom_range(255);
            for (j = 0; j < PATTERN_BYTES; j++)
                pat_all[8*j +: 8] = t_byte'(base + $urandom_range(alpha - 1));
            sel = $urandom_range(19);
            if (sel == 0) pat_all = '0;
            if (sel == 1) pat_all = '1;
            if (sel == 2) pat_all = {$urandom, $urandom, $urandom, $urandom};
            s.pat_lo = pat_all[PAT_W-1:0];
            s.pat_hi = pat_all[2*PAT_W-1:PAT_W];

            in_idle_pct = (phase >= QUIET_FIRST && phase <= QUIET_LAST) ? 0 : IDLE_PCT;
            out_idle_pct <= (phase >= QUIET_FIRST && phase <= QUIET_LAST) ? 0 : IDLE_PCT;
            apply_setting(s);
            if (phase == HOLD_OFF_PHASE) hold_off_request = 1'b1;

            // build the text: whole patterns, broken prefixes, alphabet and noise
            n = (phase == HOLD_OFF_PHASE) ? 60 : $urandom_range(60, 8);
            m = length_in_use();
            phase_text.delete();
            while (phase_text.size() < n) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    for (j = 0; j < m; j++)
                        phase_text.insert(phase_text.size(), pattern_char(j));
                end else if (r < 65) begin
                    cut = $urandom_range(m - 1);
                    for (j = 0; j < cut; j++)
                        phase_text.insert(phase_text.size(), pattern_char(j));
                    phase_text.insert(phase_text.size(),
                                      pattern_char(cut) ^ t_byte'(1 << $urandom_range(7)));
                end else if (r < 90) begin
                    repeat ($urandom_range(4, 1))
                        phase_text.insert(phase_text.size(),
                                          t_byte'(base + $urandom_range(alpha - 1)));
                end else begin
                    repeat ($urandom_range(3, 1))
                        phase_text.insert(phase_text.size(), t_byte'($urandom));
                end
            end

            // most phases open a new text, the rest run on under new registers
            new_text = ($urandom_range(99) < 80);
            for (k = 0; k < phase_text.size(); k++) begin
                offer_text_byte(phase_text[k],
                                (k == 0 && new_text) || ($urandom_range(99) < 2),
                                1'b0, '0);
                random_items++;
            end
            phase++;
        end

        // drain
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // generous limit on the whole run
    initial begin : watchdog
        #(TIMEOUT_TICKS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rhsm_pkg.sv
rtl/rhsm_mulmod.sv
rtl/rolling_hash_string_matcher.sv
test/rolling_hash_string_matcher_test.sv
